>>> src/fts_pkg.sv
// shared types and codes for the thread scheduler
`default_nettype none
package fts_pkg;

  localparam int KIND_W   = 3;
  localparam int TID_W    = 6;
  localparam int MODE_W   = 2;
  localparam int QID_W    = 3;
  localparam int STATUS_W = 2;
  localparam int WOKEN_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 3'd0,
    KIND_YIELD  = 3'd1,
    KIND_EXIT   = 3'd2,
    KIND_KILL   = 3'd3,
    KIND_SLEEP  = 3'd4,
    KIND_WAKEUP = 3'd5
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NAMED = 2'd0,
    MODE_ANY   = 2'd1,
    MODE_SELF  = 2'd2
  } yield_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_LIMIT   = 2'd3
  } status_t;

endpackage
`default_nettype wire

>>> src/fts_if.sv
// request and response channel interfaces
`default_nettype none
interface fts_req_if import fts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  target_tid;
  logic [MODE_W-1:0] yield_mode;
  logic [QID_W-1:0]  queue_id;
  logic              wake_all;
  modport source (output valid, kind, target_tid, yield_mode, queue_id, wake_all,
                  input ready);
  modport sink (input valid, kind, target_tid, yield_mode, queue_id, wake_all,
                output ready);
endinterface

interface fts_rsp_if import fts_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TID_W-1:0]    result_tid;
  logic [WOKEN_W-1:0]  woken_count;
  logic [TID_W-1:0]    running_tid;
  modport source (output valid, status, result_tid, woken_count, running_tid,
                  input ready);
  modport sink (input valid, status, result_tid, woken_count, running_tid,
                output ready);
endinterface
`default_nettype wire

>>> src/fts_free_stack.sv
// lifo stack of freed thread ids
`default_nettype none
module fts_free_stack #(
  parameter int MAX_THREADS = 64,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [IW-1:0] push_id,
  input  wire logic          pop,
  output logic [CW-1:0]      count,
  output logic [IW-1:0]      top_id
);
  logic [IW-1:0] mem [MAX_THREADS];

  always_ff @(posedge clk) begin
    if (push && count < CW'(MAX_THREADS)) begin
      mem[IW'(count)] <= push_id;
    end
    top_id <= mem[IW'(count - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (count < CW'(MAX_THREADS)) count <= count + 1'b1;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> src/fifo_thread_scheduler.sv
// thread scheduler top level: list sequencer, link memory and wait list table
// yield/exit/kill take longer for each reclaimed exited thread and each ready entry walked,
// and wakeup takes longer for each woken thread
// one request at a time; the next is taken once the result is in the output register
// throughput set by the single read port of the next-link memory walked per step
// synchronous reset empties all lists, running id 0, one live thread
`default_nettype none
module fifo_thread_scheduler import fts_pkg::*; #(
  parameter int MAX_THREADS    = 64,
  parameter int NUM_WAIT_LISTS = 8
) (
  input wire logic clk,
  input wire logic rst,
  fts_req_if.sink  req,
  fts_rsp_if.source rsp
);
  localparam int IW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int SW = $clog2(MAX_THREADS + 2);
  localparam int QW = (NUM_WAIT_LISTS > 1) ? $clog2(NUM_WAIT_LISTS) : 1;
  localparam int XW = (IW > TID_W) ? IW : TID_W;

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DISP     = 18'h00002,
    S_CR_POP   = 18'h00004,
    S_REC      = 18'h00008,
    S_REC_WAIT = 18'h00010,
    S_POST     = 18'h00020,
    S_RM_START = 18'h00040,
    S_RM_STEP  = 18'h00080,
    S_RM_WAIT  = 18'h00100,
    S_RM_LINK  = 18'h00200,
    S_LOADHEAD = 18'h00400,
    S_RM_OK    = 18'h00800,
    S_SLEEP    = 18'h01000,
    S_WK_LOAD  = 18'h02000,
    S_WAKE     = 18'h04000,
    S_WK_WAIT  = 18'h08000,
    S_WK_END   = 18'h10000,
    S_DONE     = 18'h20000
  } state_t;

  state_t state;

  logic [KIND_W-1:0]   k;
  logic [TID_W-1:0]    tgt;
  logic [MODE_W-1:0]   md;
  logic                qv;
  logic [QW-1:0]       qx;
  logic                all;
  logic [STATUS_W-1:0] st;
  logic [IW-1:0]       rtid;
  logic [WOKEN_W-1:0]  woken;
  logic [SW-1:0]       steps;
  logic [XW-1:0]       want;
  logic [IW-1:0]       cur;
  logic [IW-1:0]       prev;
  logic                ld_ret;

  logic [IW-1:0] rdy_head, rdy_tail, ex_head, ex_tail, running, wk_head;
  logic          rdy_ne, ex_ne;
  logic [CW-1:0] live;
  logic [NUM_WAIT_LISTS-1:0] wt_ne;

  logic [IW-1:0] nl_mem [MAX_THREADS];
  logic [IW-1:0] nl_rdata, nl_raddr, nl_waddr, nl_wdata;
  logic          nl_we;

  logic [IW-1:0] wt_head_mem [NUM_WAIT_LISTS];
  logic [IW-1:0] wt_tail_mem [NUM_WAIT_LISTS];
  logic [IW-1:0] wt_rh, wt_rt, wt_wh, wt_wt;
  logic          wt_we_h, wt_we_t;

  logic          ap_en;
  logic [IW-1:0] ap_id;
  logic          fs_push, fs_pop;
  logic [IW-1:0] fs_push_id, fs_top;
  logic [CW-1:0] fs_count;
  logic          rec_go, wk_go;
  logic [XW-1:0] yw;

  fts_free_stack #(.MAX_THREADS(MAX_THREADS), .IW(IW), .CW(CW)) u_free_stack (
    .clk(clk), .rst(rst), .push(fs_push), .push_id(fs_push_id), .pop(fs_pop),
    .count(fs_count), .top_id(fs_top)
  );

  assign req.ready = (state == S_IDLE);
  assign rec_go = ex_ne && (steps <= SW'(MAX_THREADS));
  assign wk_go  = wt_ne[qx] && (steps <= SW'(MAX_THREADS));
  assign yw = (md == MODE_ANY) ? XW'(rdy_head) : XW'(tgt);

  // memories
  always_ff @(posedge clk) begin
    if (nl_we) nl_mem[nl_waddr] <= nl_wdata;
    nl_rdata <= nl_mem[nl_raddr];
  end

  always_ff @(posedge clk) begin
    if (wt_we_h) wt_head_mem[qx] <= wt_wh;
    if (wt_we_t) wt_tail_mem[qx] <= wt_wt;
    wt_rh <= wt_head_mem[qx];
    wt_rt <= wt_tail_mem[qx];
  end

  // memory and append controls
  always_comb begin
    ap_en      = 1'b0;
    ap_id      = running;
    nl_we      = 1'b0;
    nl_waddr   = rdy_tail;
    nl_wdata   = running;
    nl_raddr   = rdy_head;
    wt_we_h    = 1'b0;
    wt_we_t    = 1'b0;
    wt_wh      = running;
    wt_wt      = running;
    fs_push    = 1'b0;
    fs_push_id = ex_head;
    fs_pop     = 1'b0;
    case (state)
      S_DISP: begin
        if (k == KIND_CREATE && live < CW'(MAX_THREADS) && fs_count == '0) begin
          ap_en = 1'b1;
          ap_id = IW'(live);
        end
      end
      S_CR_POP: begin
        ap_en  = 1'b1;
        ap_id  = fs_top;
        fs_pop = 1'b1;
      end
      S_REC: begin
        nl_raddr = ex_head;
        fs_push  = rec_go && (ex_head != '0);
      end
      S_POST: begin
        if (k == KIND_EXIT && rdy_ne && ex_ne) begin
          nl_we    = 1'b1;
          nl_waddr = ex_tail;
        end
      end
      S_RM_STEP: nl_raddr = cur;
      S_RM_WAIT: nl_raddr = nl_rdata;
      S_RM_LINK: begin
        nl_we    = 1'b1;
        nl_waddr = prev;
        nl_wdata = nl_rdata;
      end
      S_RM_OK: begin
        if (k == KIND_YIELD) ap_en = 1'b1;
        if (k == KIND_KILL) begin
          fs_push    = 1'b1;
          fs_push_id = IW'(want);
        end
      end
      S_SLEEP: begin
        wt_we_t = 1'b1;
        wt_we_h = !wt_ne[qx];
        if (wt_ne[qx]) begin
          nl_we    = 1'b1;
          nl_waddr = wt_rt;
        end
      end
      S_WAKE: begin
        nl_raddr = wk_head;
        if (wk_go) begin
          ap_en = 1'b1;
          ap_id = wk_head;
        end
      end
      S_WK_END: begin
        wt_we_h = 1'b1;
        wt_wh   = wk_head;
      end
      default: ;
    endcase
    if (ap_en && rdy_ne) begin
      nl_we    = 1'b1;
      nl_waddr = rdy_tail;
      nl_wdata = ap_id;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rdy_ne   <= 1'b0;
      ex_ne    <= 1'b0;
      wt_ne    <= '0;
      rdy_head <= '0;
      rdy_tail <= '0;
      ex_head  <= '0;
      ex_tail  <= '0;
      running  <= '0;
      live     <= CW'(1);
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            k     <= req.kind;
            tgt   <= req.target_tid;
            md    <= req.yield_mode;
            qv    <= 32'(req.queue_id) < NUM_WAIT_LISTS;
            qx    <= QW'(req.queue_id);
            all   <= req.wake_all;
            st    <= ST_OK;
            rtid  <= '0;
            woken <= '0;
            steps <= '0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          case (k)
            KIND_CREATE: begin
              if (live >= CW'(MAX_THREADS)) begin
                st    <= ST_LIMIT;
                state <= S_DONE;
              end else if (fs_count != '0) begin
                state <= S_CR_POP;
              end else begin
                live  <= live + 1'b1;
                rtid  <= IW'(live);
                state <= S_DONE;
              end
            end
            KIND_YIELD, KIND_EXIT, KIND_KILL: state <= S_REC;
            KIND_SLEEP: begin
              if (!qv) begin
                st    <= ST_INVALID;
                state <= S_DONE;
              end else if (!rdy_ne) begin
                st    <= ST_NONE;
                state <= S_DONE;
              end else begin
                state <= S_SLEEP;
              end
            end
            KIND_WAKEUP: state <= qv ? S_WK_LOAD : S_DONE;
            default: state <= S_DONE;
          endcase
        end
        S_CR_POP: begin
          live  <= live + 1'b1;
          rtid  <= fs_top;
          state <= S_DONE;
        end
        S_REC: begin
          if (rec_go) begin
            if (ex_head != '0 && live != '0) live <= live - 1'b1;
            if (ex_head == ex_tail) begin
              ex_ne <= 1'b0;
              steps <= steps + 1'b1;
            end else begin
              state <= S_REC_WAIT;
            end
          end else begin
            steps <= '0;
            state <= S_POST;
          end
        end
        S_REC_WAIT: begin
          ex_head <= nl_rdata;
          steps   <= steps + 1'b1;
          state   <= S_REC;
        end
        S_POST: begin
          case (k)
            KIND_YIELD: begin
              if (md == MODE_ANY && !rdy_ne) begin
                st    <= ST_NONE;
                state <= S_DONE;
              end else if (md >= MODE_SELF || yw == XW'(running)) begin
                rtid  <= running;
                state <= S_DONE;
              end else begin
                want  <= yw;
                state <= S_RM_START;
              end
            end
            KIND_EXIT: begin
              if (!rdy_ne) begin
                st    <= ST_NONE;
                state <= S_DONE;
              end else begin
                rtid    <= running;
                running <= rdy_head;
                ex_tail <= running;
                if (!ex_ne) begin
                  ex_head <= running;
                  ex_ne   <= 1'b1;
                end
                ld_ret <= 1'b0;
                if (rdy_head == rdy_tail) begin
                  rdy_ne <= 1'b0;
                  state  <= S_DONE;
                end else begin
                  state <= S_LOADHEAD;
                end
              end
            end
            default: begin
              want  <= XW'(tgt);
              state <= S_RM_START;
            end
          endcase
        end
        S_RM_START: begin
          cur   <= rdy_head;
          steps <= '0;
          if (!rdy_ne) begin
            st    <= ST_INVALID;
            state <= S_DONE;
          end else if (XW'(rdy_head) == want) begin
            ld_ret <= 1'b1;
            if (rdy_head == rdy_tail) begin
              rdy_ne <= 1'b0;
              state  <= S_RM_OK;
            end else begin
              state <= S_LOADHEAD;
            end
          end else begin
            state <= S_RM_STEP;
          end
        end
        S_RM_STEP: begin
          if (steps >= SW'(MAX_THREADS) || cur == rdy_tail) begin
            st    <= ST_INVALID;
            state <= S_DONE;
          end else begin
            prev  <= cur;
            state <= S_RM_WAIT;
          end
        end
        S_RM_WAIT: begin
          cur   <= nl_rdata;
          steps <= steps + 1'b1;
          if (XW'(nl_rdata) == want) begin
            if (nl_rdata == rdy_tail) begin
              rdy_tail <= prev;
              state    <= S_RM_OK;
            end else begin
              state <= S_RM_LINK;
            end
          end else begin
            state <= S_RM_STEP;
          end
        end
        S_RM_LINK: state <= S_RM_OK;
        S_LOADHEAD: begin
          rdy_head <= nl_rdata;
          state    <= ld_ret ? S_RM_OK : S_DONE;
        end
        S_RM_OK: begin
          rtid <= IW'(want);
          if (k == KIND_YIELD) begin
            running <= IW'(want);
          end else if (live != '0) begin
            live <= live - 1'b1;
          end
          state <= S_DONE;
        end
        S_SLEEP: begin
          running   <= rdy_head;
          rtid      <= rdy_head;
          wt_ne[qx] <= 1'b1;
          ld_ret    <= 1'b0;
          if (rdy_head == rdy_tail) begin
            rdy_ne <= 1'b0;
            state  <= S_DONE;
          end else begin
            state <= S_LOADHEAD;
          end
        end
        S_WK_LOAD: begin
          wk_head <= wt_rh;
          state   <= S_WAKE;
        end
        S_WAKE: begin
          if (wk_go) begin
            woken <= woken + 1'b1;
            if (wk_head == wt_rt) begin
              wt_ne[qx] <= 1'b0;
              steps     <= steps + 1'b1;
              if (!all) state <= S_WK_END;
            end else begin
              state <= S_WK_WAIT;
            end
          end else begin
            state <= S_WK_END;
          end
        end
        S_WK_WAIT: begin
          wk_head <= nl_rdata;
          steps   <= steps + 1'b1;
          state   <= all ? S_WAKE : S_WK_END;
        end
        S_WK_END: state <= S_DONE;
        S_DONE: begin
          if (!rsp.valid || rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (ap_en) begin
        rdy_tail <= ap_id;
        if (!rdy_ne) begin
          rdy_head <= ap_id;
          rdy_ne   <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status      <= st;
      rsp.result_tid  <= TID_W'(rtid);
      rsp.woken_count <= woken;
      rsp.running_tid <= TID_W'(running);
    end
  end
endmodule
`default_nettype wire

>>> src/fts_checker.sv
// port level checks for the thread scheduler and their bind
`default_nettype none
module fts_checker import fts_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [TID_W-1:0]    result_tid,
  input wire logic [WOKEN_W-1:0]  woken_count
);
  // a pending response transaction stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_fail_tid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK || result_tid == '0))
    else $error("failed request returned a thread id");

  a_woken_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && woken_count != '0 |-> status == ST_OK)
    else $error("woken count on a failed request");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response after reset");
endmodule

bind fifo_thread_scheduler fts_checker u_fts_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .result_tid(rsp.result_tid),
  .woken_count(rsp.woken_count)
);
`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the thread scheduler with its own list predictor
`timescale 1ns / 100ps
module testbench;
  import fts_pkg::*;

  localparam int NTHR = 64;
  localparam int NWAIT = 8;
  localparam int NLST = 2 + NWAIT;
  localparam int RDY = 0;
  localparam int EXL = 1;

  typedef struct packed {
    status_t            status;
    logic [TID_W-1:0]   result_tid;
    logic [WOKEN_W-1:0] woken_count;
    logic [TID_W-1:0]   running_tid;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fts_req_if req_ch ();
  fts_rsp_if rsp_ch ();

  fifo_thread_scheduler dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted scheduler state
  logic [TID_W-1:0] nxt_tbl [NTHR];
  logic [TID_W-1:0] lhead [NLST];
  logic [TID_W-1:0] ltail [NLST];
  logic             lbusy [NLST];
  logic [TID_W-1:0] cur_tid;
  int               live_thr;
  logic [TID_W-1:0] freed_ids [NTHR];
  int               freed_cnt;

  sched_rsp_t pending_rsp [$];
  int         err_cnt = 0;
  int         rsp_seen = 0;
  int         kind_cnt [8];
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         limit_hits = 0;

  function automatic void lst_append(int l, logic [TID_W-1:0] id);
    if (lbusy[l]) begin
      nxt_tbl[ltail[l]] = id;
      ltail[l] = id;
    end else begin
      lhead[l] = id;
      ltail[l] = id;
      lbusy[l] = 1'b1;
    end
  endfunction

  function automatic logic [TID_W-1:0] lst_pop(int l);
    logic [TID_W-1:0] h;
    h = lhead[l];
    if (h == ltail[l]) lbusy[l] = 1'b0;
    else lhead[l] = nxt_tbl[h];
    return h;
  endfunction

  function automatic bit lst_remove(int l, logic [TID_W-1:0] id);
    logic [TID_W-1:0] c;
    logic [TID_W-1:0] p;
    logic [TID_W-1:0] dummy;
    if (!lbusy[l]) return 0;
    c = lhead[l];
    if (c == id) begin
      dummy = lst_pop(l);
      return 1;
    end
    for (int s = 0; s < NTHR; s++) begin
      if (c == ltail[l]) return 0;
      p = c;
      c = nxt_tbl[c];
      if (c == id) begin
        if (c == ltail[l]) ltail[l] = p;
        else nxt_tbl[p] = nxt_tbl[c];
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void release_tid(logic [TID_W-1:0] id);
    if (freed_cnt < NTHR) begin
      freed_ids[freed_cnt] = id;
      freed_cnt++;
    end
    if (live_thr > 0) live_thr--;
  endfunction

  function automatic void reap_exited();
    logic [TID_W-1:0] id;
    for (int s = 0; s <= NTHR && lbusy[EXL]; s++) begin
      id = lst_pop(EXL);
      if (id != 0) release_tid(id);
    end
  endfunction

  function automatic void sched_reset();
    for (int l = 0; l < NLST; l++) begin
      lhead[l] = '0;
      ltail[l] = '0;
      lbusy[l] = 1'b0;
    end
    cur_tid = '0;
    live_thr = 1;
    freed_cnt = 0;
  endfunction

  function automatic sched_rsp_t sched_predict(logic [KIND_W-1:0] k, logic [TID_W-1:0] tgt,
                                               logic [MODE_W-1:0] md, logic [QID_W-1:0] q,
                                               logic all);
    sched_rsp_t r;
    logic [TID_W-1:0] id;
    logic [TID_W-1:0] want;
    int woken;
    r = '0;
    r.status = ST_OK;
    woken = 0;
    case (k)
      KIND_CREATE: begin
        if (live_thr >= NTHR) begin
          r.status = ST_LIMIT;
        end else begin
          if (freed_cnt > 0) begin
            freed_cnt--;
            id = freed_ids[freed_cnt];
          end else begin
            id = live_thr[TID_W-1:0];
          end
          live_thr++;
          lst_append(RDY, id);
          r.result_tid = id;
        end
      end
      KIND_YIELD: begin
        reap_exited();
        want = tgt;
        if (md == MODE_ANY && !lbusy[RDY]) begin
          r.status = ST_NONE;
        end else begin
          if (md == MODE_ANY) want = lhead[RDY];
          if (md >= MODE_SELF || want == cur_tid) begin
            r.result_tid = cur_tid;
          end else if (!lst_remove(RDY, want)) begin
            r.status = ST_INVALID;
          end else begin
            lst_append(RDY, cur_tid);
            cur_tid = want;
            r.result_tid = want;
          end
        end
      end
      KIND_EXIT: begin
        reap_exited();
        if (!lbusy[RDY]) begin
          r.status = ST_NONE;
        end else begin
          id = lst_pop(RDY);
          r.result_tid = cur_tid;
          lst_append(EXL, cur_tid);
          cur_tid = id;
        end
      end
      KIND_KILL: begin
        reap_exited();
        if (!lst_remove(RDY, tgt)) begin
          r.status = ST_INVALID;
        end else begin
          release_tid(tgt);
          r.result_tid = tgt;
        end
      end
      KIND_SLEEP: begin
        if (q >= NWAIT) begin
          r.status = ST_INVALID;
        end else if (!lbusy[RDY]) begin
          r.status = ST_NONE;
        end else begin
          id = lst_pop(RDY);
          lst_append(2 + q, cur_tid);
          cur_tid = id;
          r.result_tid = id;
        end
      end
      KIND_WAKEUP: begin
        if (q < NWAIT) begin
          for (int s = 0; s <= NTHR && lbusy[2 + q]; s++) begin
            lst_append(RDY, lst_pop(2 + q));
            woken++;
            if (!all) break;
          end
        end
      end
      default: ;
    endcase
    r.woken_count = woken[WOKEN_W-1:0];
    r.running_tid = cur_tid;
    return r;
  endfunction

  task automatic send_req(logic [KIND_W-1:0] k, logic [TID_W-1:0] tgt = '0,
                          logic [MODE_W-1:0] md = MODE_NAMED, logic [QID_W-1:0] q = '0,
                          logic all = 1'b0);
    sched_rsp_t r;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= k;
    req_ch.target_tid <= tgt;
    req_ch.yield_mode <= md;
    req_ch.queue_id   <= q;
    req_ch.wake_all   <= all;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = sched_predict(k, tgt, md, q, all);
    if (r.status == ST_LIMIT) limit_hits++;
    kind_cnt[k]++;
    pending_rsp.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst) rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    sched_rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        $error("unexpected transaction: status %0d result_tid %0d", rsp_ch.status,
               rsp_ch.result_tid);
        err_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_ch.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp_ch.status);
          err_cnt++;
        end
        if (rsp_ch.result_tid !== e.result_tid) begin
          $error("result_tid expected %0d actual %0d", e.result_tid, rsp_ch.result_tid);
          err_cnt++;
        end
        if (rsp_ch.woken_count !== e.woken_count) begin
          $error("woken_count expected %0d actual %0d", e.woken_count, rsp_ch.woken_count);
          err_cnt++;
        end
        if (rsp_ch.running_tid !== e.running_tid) begin
          $error("running_tid expected %0d actual %0d", e.running_tid, rsp_ch.running_tid);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(KIND_EXIT);
    send_req(KIND_SLEEP, '0, MODE_NAMED, 3'd2);
    send_req(KIND_YIELD, '0, MODE_ANY);
    send_req(KIND_CREATE);
    send_req(KIND_CREATE);
    send_req(KIND_CREATE);
    send_req(KIND_CREATE);
    send_req(KIND_EXIT);
    send_req(KIND_YIELD, 6'd3, MODE_NAMED);
    send_req(KIND_YIELD, cur_tid, MODE_NAMED);
    send_req(KIND_YIELD, 6'd63, MODE_NAMED);
    send_req(KIND_YIELD, '0, MODE_SELF);
    send_req(KIND_YIELD, '0, 2'd3);
    send_req(KIND_YIELD, '0, MODE_ANY);
    send_req(KIND_KILL, 6'd2);
    send_req(KIND_KILL, 6'd63);
    send_req(KIND_CREATE);
    send_req(KIND_SLEEP, '0, MODE_NAMED, 3'd7);
    send_req(KIND_SLEEP, '0, MODE_NAMED, 3'd0);
    send_req(KIND_WAKEUP, '0, MODE_NAMED, 3'd3, 1'b1);
    send_req(KIND_WAKEUP, '0, MODE_NAMED, 3'd7, 1'b0);
    send_req(KIND_WAKEUP, '0, MODE_NAMED, 3'd0, 1'b1);
    send_req(3'd6, 6'd63, 2'd3, 3'd7, 1'b1);
    send_req(3'd7, 6'd21, 2'd1, 3'd5, 1'b0);
  endtask

  task automatic test_thread_limit();
    while (live_thr < NTHR) send_req(KIND_CREATE);
    send_req(KIND_CREATE);
    send_req(KIND_CREATE);
    repeat (20) send_req(KIND_KILL, 6'($urandom_range(0, NTHR - 1)));
    repeat (10) send_req(KIND_EXIT);
    send_req(KIND_YIELD, '0, MODE_SELF);
  endtask

  task automatic test_random(int n);
    int w;
    logic [TID_W-1:0] tgt;
    logic [QID_W-1:0] q;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      q = $urandom_range(0, 1) ? 3'($urandom_range(0, 2)) : 3'($urandom);
      tgt = $urandom_range(0, 2) != 0 ? 6'($urandom_range(0, live_thr + 2)) : 6'($urandom);
      if (w < (live_thr < 8 ? 35 : 18)) send_req(KIND_CREATE);
      else if (w < 45) send_req(KIND_YIELD, tgt, 2'($urandom), q, 1'($urandom));
      else if (w < 56) send_req(KIND_EXIT, tgt, 2'($urandom), q, 1'($urandom));
      else if (w < 68) send_req(KIND_KILL, tgt, 2'($urandom), q, 1'($urandom));
      else if (w < 83) send_req(KIND_SLEEP, tgt, 2'($urandom), q, 1'($urandom));
      else if (w < 97) send_req(KIND_WAKEUP, tgt, 2'($urandom), q, 1'($urandom));
      else send_req(3'($urandom_range(6, 7)), 6'($urandom), 2'($urandom), 3'($urandom),
                    1'($urandom));
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_CREATE;
    req_ch.target_tid = '0;
    req_ch.yield_mode = MODE_NAMED;
    req_ch.queue_id = '0;
    req_ch.wake_all = 1'b0;
    rsp_ch.ready = 1'b0;
    foreach (kind_cnt[i]) kind_cnt[i] = 0;
    sched_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    tx_idle_pct = 26;
    rx_idle_pct = 73;
    test_random(600);
    test_thread_limit();
    tx_idle_pct = 73;
    rx_idle_pct = 26;
    test_random(600);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(550);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("requests: create %0d yield %0d exit %0d kill %0d sleep %0d wakeup %0d other %0d",
             kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], kind_cnt[4], kind_cnt[5],
             kind_cnt[6] + kind_cnt[7]);
    $display("%0d responses checked, thread limit reached %0d times", rsp_seen, limit_hits);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
